@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TRK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TRK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define TRK_ASSERT(lbl, clk, rst, prop, msg)
`define TRK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/trk_pkg.sv @@
`timescale 1ns / 1ps
package trk_pkg;
   localparam int OP_W        = 3;
   localparam int KIND_W      = 4;
   localparam int EP_W        = 48;
   localparam int TXN_W       = 16;
   localparam int TIME_W      = 32;
   localparam int SLOT_W      = 4;
   localparam int RTT_W       = 16;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [OP_W-1:0] OP_ISSUE    = 3'd0;
   localparam logic [OP_W-1:0] OP_ONESHOT  = 3'd1;
   localparam logic [OP_W-1:0] OP_RESPONSE = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd3;
   localparam logic [OP_W-1:0] OP_CANCEL   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_SEED       = 2'd2;

   localparam logic [TXN_W-1:0]  LFSR_MASK     = 16'hB400;
   localparam logic [TXN_W-1:0]  RTT_MAX       = 16'hFFFE;
   localparam logic [TXN_W-1:0]  SEED_RESET    = 16'd44257;
   localparam logic [TIME_W-1:0] SHORT_RESET   = 32'd2000;
   localparam logic [TIME_W-1:0] FULL_RESET    = 32'd15000;

   typedef enum logic [KIND_W-1:0] {
      KIND_ISSUED        = 4'd0,
      KIND_ONESHOT       = 4'd1,
      KIND_REPLY_OK      = 4'd2,
      KIND_ERROR_REPLY   = 4'd3,
      KIND_BAD_ID        = 4'd4,
      KIND_UNKNOWN       = 4'd5,
      KIND_SPOOFED       = 4'd6,
      KIND_SHORT_TIMEOUT = 4'd7,
      KIND_FULL_TIMEOUT  = 4'd8,
      KIND_FULL_TABLE    = 4'd9,
      KIND_CANCEL_DONE   = 4'd10,
      KIND_TICK_IDLE     = 4'd11
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FREE, ST_STEP, ST_RD, ST_AGE, ST_EVAL, ST_BADID, ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      PH_DRAW, PH_FIND, PH_SHORT, PH_FULL
   } phase_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_CAPTURE, CMD_LFSR_STEP, CMD_READ, CMD_AGE,
      CMD_ISSUE_DONE, CMD_ONESHOT_DONE, CMD_BAD_ID, CMD_UNKNOWN,
      CMD_SPOOF, CMD_REPLY, CMD_CANCEL, CMD_FULL_TABLE,
      CMD_Q_SHORT, CMD_Q_FULL, CMD_FLUSH
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic pend_valid;
      logic valid_cur;
      logic hit_tid;
      logic hit_lfsr;
      logic ep_match;
      logic is_short;
      logic is_full;
   } status_type;

   function automatic logic [TXN_W-1:0] lfsr_next(input logic [TXN_W-1:0] s);
      logic [TXN_W-1:0] n;
      n = s >> 1;
      if (s[0]) n = n ^ LFSR_MASK;
      return n;
   endfunction
endpackage

@@ rtl/trk_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trk_dp
   import trk_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [EP_W-1:0]       req_endpoint,
   input  logic [TXN_W-1:0]      req_txn_id,
   input  logic                  req_is_error,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [TXN_W-1:0]      rsp_txn,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [RTT_W-1:0]      rsp_rtt,
   output logic                  rsp_last,
   input  cmd_type               cmd,
   input  logic [IDX_W-1:0]      idx_i,
   input  logic [IDX_W-1:0]      slot_i,
   output status_type            status
);
   localparam int MEM_W = TXN_W + EP_W + TIME_W;

   logic [TIME_W-1:0] short_ff, full_ff, now_ff;
   logic [TXN_W-1:0]  lfsr_ff, tid_ff;
   logic [EP_W-1:0]   ep_ff;
   logic              err_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, fired_ff;
   logic [MEM_W-1:0]  mem_ff [TABLE_ENTRIES];
   logic [TXN_W-1:0]  rd_txn_ff;
   logic [EP_W-1:0]   rd_ep_ff;
   logic [TIME_W-1:0] rd_sent_ff, age_ff, diff;
   logic              pend_valid_ff;
   kind_type          pend_kind_ff;
   logic [TXN_W-1:0]  pend_txn_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   kind_type          rsp_kind_ff;
   logic [TXN_W-1:0]  rsp_txn_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [RTT_W-1:0]  rsp_rtt_ff;

   logic              push, push_last, out_free, ge_full, ge_short;
   kind_type          push_kind;
   logic [TXN_W-1:0]  push_txn;
   logic [SLOT_W-1:0] push_slot;
   logic [RTT_W-1:0]  push_rtt, rtt;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign diff     = now_ff - rd_sent_ff;
   assign ge_full  = age_ff >= full_ff;
   assign ge_short = age_ff >= short_ff;
   assign rtt      = (age_ff > {16'h0, RTT_MAX}) ? RTT_MAX : age_ff[RTT_W-1:0];

   always_comb begin
      status.out_free   = out_free;
      status.pend_valid = pend_valid_ff;
      status.valid_cur  = valid_ff[idx_i];
      status.hit_tid    = valid_ff[idx_i] && (rd_txn_ff == tid_ff);
      status.hit_lfsr   = valid_ff[idx_i] && (rd_txn_ff == lfsr_ff);
      status.ep_match   = rd_ep_ff == ep_ff;
      status.is_full    = valid_ff[idx_i] && ge_full;
      status.is_short   = valid_ff[idx_i] && !ge_full && ge_short && !fired_ff[idx_i];
   end

   always_comb begin
      push      = 1'b0;
      push_last = 1'b1;
      push_kind = KIND_TICK_IDLE;
      push_txn  = '0;
      push_slot = '0;
      push_rtt  = '0;
      unique case (cmd)
         CMD_ISSUE_DONE: begin
            push = 1'b1; push_kind = KIND_ISSUED; push_txn = lfsr_ff;
            push_slot = SLOT_W'(slot_i);
         end
         CMD_ONESHOT_DONE: begin
            push = 1'b1; push_kind = KIND_ONESHOT; push_txn = lfsr_ff;
         end
         CMD_BAD_ID: begin
            push = 1'b1; push_kind = KIND_BAD_ID;
         end
         CMD_UNKNOWN: begin
            push = 1'b1; push_kind = KIND_UNKNOWN; push_txn = tid_ff;
         end
         CMD_SPOOF: begin
            push = 1'b1; push_kind = KIND_SPOOFED; push_txn = tid_ff;
            push_slot = SLOT_W'(idx_i);
         end
         CMD_REPLY: begin
            push = 1'b1; push_kind = err_ff ? KIND_ERROR_REPLY : KIND_REPLY_OK;
            push_txn = tid_ff; push_slot = SLOT_W'(idx_i); push_rtt = rtt;
         end
         CMD_CANCEL: begin
            push = 1'b1; push_kind = KIND_CANCEL_DONE; push_txn = tid_ff;
            push_slot = SLOT_W'(idx_i);
         end
         CMD_FULL_TABLE: begin
            push = 1'b1; push_kind = KIND_FULL_TABLE;
         end
         CMD_Q_SHORT, CMD_Q_FULL: begin
            // the held result goes out only once a later one is known
            push = pend_valid_ff; push_last = 1'b0; push_kind = pend_kind_ff;
            push_txn = pend_txn_ff; push_slot = pend_slot_ff;
         end
         CMD_FLUSH: begin
            push = 1'b1;
            if (pend_valid_ff) begin
               push_kind = pend_kind_ff; push_txn = pend_txn_ff;
               push_slot = pend_slot_ff;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff      <= SHORT_RESET;
         full_ff       <= FULL_RESET;
         lfsr_ff       <= SEED_RESET;
         valid_ff      <= '0;
         fired_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd == CMD_LFSR_STEP) lfsr_ff <= lfsr_next(lfsr_ff);
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SHORT_TIMEOUT: short_ff <= csr_wdata;
               CSR_FULL_TIMEOUT:  full_ff  <= csr_wdata;
               CSR_ID_SEED: begin
                  lfsr_ff <= (csr_wdata[TXN_W-1:0] == '0) ? TXN_W'(1) : csr_wdata[TXN_W-1:0];
               end
               default: begin
               end
            endcase
         end
         unique case (cmd)
            CMD_ISSUE_DONE: begin
               valid_ff[slot_i] <= 1'b1;
               fired_ff[slot_i] <= 1'b0;
            end
            CMD_REPLY, CMD_CANCEL: valid_ff[idx_i] <= 1'b0;
            CMD_Q_SHORT: begin
               fired_ff[idx_i] <= 1'b1;
               pend_valid_ff   <= 1'b1;
            end
            CMD_Q_FULL: begin
               valid_ff[idx_i] <= 1'b0;
               pend_valid_ff   <= 1'b1;
            end
            CMD_FLUSH: pend_valid_ff <= 1'b0;
            default: begin
            end
         endcase
         if (push) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_CAPTURE) begin
         ep_ff  <= req_endpoint;
         tid_ff <= req_txn_id;
         err_ff <= req_is_error;
         now_ff <= req_now_ms;
      end
      if (cmd == CMD_ISSUE_DONE) mem_ff[slot_i] <= {lfsr_ff, ep_ff, now_ff};
      if (cmd == CMD_READ) {rd_txn_ff, rd_ep_ff, rd_sent_ff} <= mem_ff[idx_i];
      if (cmd == CMD_AGE) age_ff <= diff[TIME_W-1] ? '0 : diff;
      if (cmd == CMD_Q_SHORT || cmd == CMD_Q_FULL) begin
         pend_kind_ff <= (cmd == CMD_Q_SHORT) ? KIND_SHORT_TIMEOUT : KIND_FULL_TIMEOUT;
         pend_txn_ff  <= rd_txn_ff;
         pend_slot_ff <= SLOT_W'(idx_i);
      end
      if (push) begin
         rsp_kind_ff <= push_kind;
         rsp_txn_ff  <= push_txn;
         rsp_slot_ff <= push_slot;
         rsp_rtt_ff  <= push_rtt;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_txn    = rsp_txn_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_rtt    = rsp_rtt_ff;
   assign rsp_last   = rsp_last_ff;

   `TRK_ASSERT_IMP(a_push_free, clock, reset, push, out_free, "result pushed over a held one")
   `TRK_ASSERT_IMP(a_issue_slot_free, clock, reset, cmd == CMD_ISSUE_DONE, !valid_ff[slot_i], "issue into a busy slot")
   `TRK_ASSERT(a_lfsr_nonzero, clock, reset, lfsr_ff != '0, "id generator stuck at zero")
endmodule

@@ rtl/trk_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trk_ctrl
   import trk_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [OP_W-1:0]  req_op,
   input  logic             req_txn_ok,
   input  status_type       status,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] idx_o,
   output logic [IDX_W-1:0] slot_o
);
   localparam int DRAW_W = $clog2(TABLE_ENTRIES + 2);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, slot_ff, slot_in;
   logic [DRAW_W-1:0] draw_ff, draw_in;
   logic              last_idx, go;

   assign last_idx = idx_ff == IDX_W'(TABLE_ENTRIES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DRAW;
         op_ff    <= OP_ISSUE;
         idx_ff   <= '0;
         slot_ff  <= '0;
         draw_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         slot_ff  <= slot_in;
         draw_ff  <= draw_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      slot_in    = slot_ff;
      draw_in    = draw_ff;
      cmd        = CMD_NONE;
      req_tready = 1'b0;
      go         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd     = CMD_CAPTURE;
               op_in   = req_op;
               idx_in  = '0;
               draw_in = '0;
               unique case (req_op)
                  OP_ISSUE:    state_in = ST_FREE;
                  OP_ONESHOT:  state_in = ST_STEP;
                  OP_RESPONSE: begin
                     phase_in = PH_FIND;
                     state_in = req_txn_ok ? ST_RD : ST_BADID;
                  end
                  OP_TICK: begin
                     phase_in = PH_SHORT;
                     state_in = ST_RD;
                  end
                  OP_CANCEL: begin
                     phase_in = PH_FIND;
                     state_in = ST_RD;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FREE: begin
            if (!status.valid_cur) begin
               slot_in  = idx_ff;
               state_in = ST_STEP;
            end else if (last_idx) begin
               if (status.out_free) begin
                  cmd      = CMD_FULL_TABLE;
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_STEP: begin
            cmd      = CMD_LFSR_STEP;
            draw_in  = draw_ff + 1'b1;
            idx_in   = '0;
            phase_in = PH_DRAW;
            state_in = ST_RD;
         end
         ST_RD: begin
            cmd      = CMD_READ;
            state_in = ST_AGE;
         end
         ST_AGE: begin
            cmd      = CMD_AGE;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            unique case (phase_ff)
               PH_DRAW: begin
                  if (status.hit_lfsr && draw_ff < DRAW_W'(TABLE_ENTRIES + 1)) begin
                     state_in = ST_STEP;
                  end else if (status.hit_lfsr || last_idx) begin
                     if (status.out_free) begin
                        cmd      = (op_ff == OP_ISSUE) ? CMD_ISSUE_DONE : CMD_ONESHOT_DONE;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end
               PH_FIND: begin
                  if (status.hit_tid) begin
                     if (status.out_free) begin
                        if (op_ff == OP_CANCEL) cmd = CMD_CANCEL;
                        else if (!status.ep_match) cmd = CMD_SPOOF;
                        else cmd = CMD_REPLY;
                        state_in = ST_IDLE;
                     end
                  end else if (last_idx) begin
                     if (status.out_free) begin
                        cmd      = CMD_UNKNOWN;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end
               PH_SHORT: begin
                  go = !status.is_short || !status.pend_valid || status.out_free;
                  if (go) begin
                     if (status.is_short) cmd = CMD_Q_SHORT;
                     state_in = ST_RD;
                     if (last_idx) begin
                        phase_in = PH_FULL;
                        idx_in   = '0;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
               end
               PH_FULL: begin
                  go = !status.is_full || !status.pend_valid || status.out_free;
                  if (go) begin
                     if (status.is_full) cmd = CMD_Q_FULL;
                     if (last_idx) begin
                        state_in = ST_FLUSH;
                     end else begin
                        idx_in   = idx_ff + 1'b1;
                        state_in = ST_RD;
                     end
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_BADID: begin
            if (status.out_free) begin
               cmd      = CMD_BAD_ID;
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd      = CMD_FLUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign idx_o  = idx_ff;
   assign slot_o = slot_ff;

   `TRK_ASSERT_IMP(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !status.pend_valid, "held tick result left behind")
   `TRK_ASSERT(a_draw_bound, clock, reset, draw_ff <= DRAW_W'(TABLE_ENTRIES + 1), "too many id draws")
   `TRK_ASSERT(a_idx_range, clock, reset, idx_ff <= IDX_W'(TABLE_ENTRIES - 1), "scan index past table")
endmodule

@@ rtl/rpc_transaction_tracker_core.sv @@
`timescale 1ns / 1ps
// Sequence per item, N = TABLE_ENTRIES, one memory read port; each scanned entry is read, aged, then evaluated.
//   issue: free-slot scan of up to N entries, then a table scan per id draw, up to N+1 draws;
//   oneshot: id draws only; response/cancel: one table scan up to a hit; tick: short pass, full pass, flush.
// Throughput: one item at a time; the next item is taken once the last result is registered.
// Reset: synchronous, active high; clears all entries, loads default timeouts and the id seed.
module rpc_transaction_tracker_core
   import trk_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: endpoint[47:0], txn_id[63:48], txn_ok[64], is_error[65], now_ms[97:66]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,   // operation
   // rsp_tdata: txn_out[15:0], slot[19:16], rtt_ms[35:20]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]      rsp_tuser,   // kind
   output logic                   rsp_tlast,
   // register writes, to be made only while the block is idle; the block itself does not enforce it
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   cmd_type           cmd;
   status_type        status;
   logic [IDX_W-1:0]  idx, slot;
   logic [TXN_W-1:0]  rsp_txn;
   logic [SLOT_W-1:0] rsp_slot;
   logic [RTT_W-1:0]  rsp_rtt;

   assign csr_ready = 1'b1;

   // sequencer: scan index, draw count, phase of a tick
   trk_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_txn_ok (req_tdata[64]),
      .status     (status),
      .cmd        (cmd),
      .idx_o      (idx),
      .slot_o     (slot)
   );

   // table memory, valid/fired bits, id generator, held tick result, output register
   trk_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_endpoint (req_tdata[47:0]),
      .req_txn_id   (req_tdata[63:48]),
      .req_is_error (req_tdata[65]),
      .req_now_ms   (req_tdata[97:66]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_txn      (rsp_txn),
      .rsp_slot     (rsp_slot),
      .rsp_rtt      (rsp_rtt),
      .rsp_last     (rsp_tlast),
      .cmd          (cmd),
      .idx_i        (idx),
      .slot_i       (slot),
      .status       (status)
   );

   assign rsp_tdata = {4'b0, rsp_rtt, rsp_slot, rsp_txn};
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import trk_pkg::*;

   localparam int NSLOT = 16;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always #1 clock = ~clock;

   rpc_transaction_tracker_core DUT (.*);

   typedef struct packed {
      kind_type kind;
      logic [TXN_W-1:0] txn;
      logic [SLOT_W-1:0] slot;
      logic [RTT_W-1:0] rtt;
      logic last;
   } result_type;

   // tracker model state
   logic [TIME_W-1:0] short_to, full_to;
   logic [TXN_W-1:0] lfsr;
   logic pend [NSLOT];
   logic fired [NSLOT];
   logic [TXN_W-1:0] tbl_txn [NSLOT];
   logic [EP_W-1:0] tbl_ep [NSLOT];
   logic [TIME_W-1:0] tbl_sent [NSLOT];

   result_type expected_results[$];
   int errors = 0;
   int n_items = 0;
   int n_results = 0;
   int idle_cycles = 0;
   int kind_seen [16];

   function automatic int lookup(logic [TXN_W-1:0] t);
      for (int i = 0; i < NSLOT; i++)
         if (pend[i] && tbl_txn[i] == t) return i;
      return -1;
   endfunction

   function automatic logic [TXN_W-1:0] next_id();
      logic [TXN_W-1:0] s;
      for (int n = 0; n <= NSLOT; n++) begin
         s = lfsr >> 1;
         if (lfsr[0]) s = s ^ 16'hB400;
         lfsr = s;
         if (lookup(lfsr) < 0) break;
      end
      return lfsr;
   endfunction

   function automatic logic [TIME_W-1:0] age(int i, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] a;
      a = now - tbl_sent[i];
      return a[31] ? '0 : a;
   endfunction

   function automatic void push(kind_type k, logic [TXN_W-1:0] t, int s, logic [RTT_W-1:0] r);
      result_type x;
      x.kind = k; x.txn = t; x.slot = s[SLOT_W-1:0]; x.rtt = r; x.last = 1'b0;
      expected_results.insert(expected_results.size(), x);
   endfunction

   function automatic void predict_item(logic [OP_W-1:0] op, logic [EP_W-1:0] ep,
                                        logic [TXN_W-1:0] tid, logic tok, logic err,
                                        logic [TIME_W-1:0] now);
      int base, s;
      logic [TIME_W-1:0] a;
      logic is_full [NSLOT];
      logic is_short [NSLOT];
      logic [TXN_W-1:0] t;
      base = expected_results.size();
      case (op)
         OP_ISSUE: begin
            s = -1;
            for (int i = 0; i < NSLOT; i++)
               if (!pend[i] && s < 0) s = i;
            if (s < 0) push(KIND_FULL_TABLE, '0, 0, '0);
            else begin
               t = next_id();
               pend[s] = 1'b1; tbl_txn[s] = t; tbl_ep[s] = ep;
               tbl_sent[s] = now; fired[s] = 1'b0;
               push(KIND_ISSUED, t, s, '0);
            end
         end
         OP_ONESHOT: begin
            t = next_id();
            push(KIND_ONESHOT, t, 0, '0);
         end
         OP_RESPONSE: begin
            if (!tok) push(KIND_BAD_ID, '0, 0, '0);
            else begin
               s = lookup(tid);
               if (s < 0) push(KIND_UNKNOWN, tid, 0, '0);
               else if (tbl_ep[s] != ep) push(KIND_SPOOFED, tid, s, '0);
               else begin
                  a = age(s, now);
                  pend[s] = 1'b0;
                  push(err ? KIND_ERROR_REPLY : KIND_REPLY_OK, tid, s,
                       a > 32'hFFFE ? 16'hFFFE : a[15:0]);
               end
            end
         end
         OP_TICK: begin
            // classify all entries before freeing any
            for (int i = 0; i < NSLOT; i++) begin
               a = pend[i] ? age(i, now) : '0;
               is_full[i] = pend[i] && a >= full_to;
               is_short[i] = pend[i] && !is_full[i] && a >= short_to && !fired[i];
            end
            for (int i = 0; i < NSLOT; i++)
               if (is_short[i]) begin
                  fired[i] = 1'b1;
                  push(KIND_SHORT_TIMEOUT, tbl_txn[i], i, '0);
               end
            for (int i = 0; i < NSLOT; i++)
               if (is_full[i]) begin
                  pend[i] = 1'b0;
                  push(KIND_FULL_TIMEOUT, tbl_txn[i], i, '0);
               end
            if (expected_results.size() == base) push(KIND_TICK_IDLE, '0, 0, '0);
         end
         OP_CANCEL: begin
            s = lookup(tid);
            if (s < 0) push(KIND_UNKNOWN, tid, 0, '0);
            else begin
               pend[s] = 1'b0;
               push(KIND_CANCEL_DONE, tid, s, '0);
            end
         end
         default: ;   // undefined opcodes are dropped
      endcase
      if (expected_results.size() > base)
         expected_results[expected_results.size()-1].last = 1'b1;
   endfunction

   task automatic random_gap(int long_pct);
      int n;
      n = ($urandom_range(99) < long_pct) ? $urandom_range(40, 8) : $urandom_range(3, 1);
      repeat (n) @(negedge clock);
   endtask

   // one request item; model updated at acceptance
   task automatic send_item(logic [OP_W-1:0] op, logic [EP_W-1:0] ep,
                            logic [TXN_W-1:0] tid, logic tok, logic err,
                            logic [TIME_W-1:0] now);
      random_gap(5);
      req_tuser <= op;
      req_tdata <= {6'b0, now, err, tok, tid, ep};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(op, ep, tid, tok, err, now);
      n_items++;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain();
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SHORT_TIMEOUT: short_to = val;
         CSR_FULL_TIMEOUT:  full_to = val;
         CSR_ID_SEED:       lfsr = (val[15:0] == 0) ? 16'd1 : val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (expected_results.size() == 0) begin
            $error("unexpected result kind %0d", rsp_tuser);
            errors++;
         end else begin
            e = expected_results.pop_front();
            kind_seen[e.kind]++;
            if (rsp_tuser !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_tuser); errors++;
            end
            if (rsp_tdata[15:0] !== e.txn) begin
               $error("txn_out exp %h got %h", e.txn, rsp_tdata[15:0]); errors++;
            end
            if (rsp_tdata[19:16] !== e.slot) begin
               $error("slot exp %0d got %0d", e.slot, rsp_tdata[19:16]); errors++;
            end
            if (rsp_tdata[35:20] !== e.rtt) begin
               $error("rtt_ms exp %0d got %0d", e.rtt, rsp_tdata[35:20]); errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last exp %0b got %0b", e.last, rsp_tlast); errors++;
            end
         end
      end
   end

   // receiver stalls: mostly short, some long, some stretches always ready
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if ($urandom_range(3) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(60, 10)) @(negedge clock);
         end else if ($urandom_range(30) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(40, 10);
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(2) != 0);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   logic [TIME_W-1:0] clk_ms = 32'd1000;

   function automatic logic [EP_W-1:0] rand_ep();
      return 48'({$urandom(), $urandom()});
   endfunction

   function automatic logic [TXN_W-1:0] some_pending_id();
      int s;
      s = $urandom_range(NSLOT-1);
      for (int i = 0; i < NSLOT; i++)
         if (pend[(s+i) % NSLOT]) return tbl_txn[(s+i) % NSLOT];
      return 16'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [EP_W-1:0] ep_of(logic [TXN_W-1:0] t);
      int s;
      s = lookup(t);
      return s < 0 ? rand_ep() : tbl_ep[s];
   endfunction

   task automatic test_directed();
      logic [TXN_W-1:0] t;
      send_item(OP_TICK, '0, '0, 1'b0, 1'b0, 32'd0);                       // empty tick
      send_item(OP_ISSUE, 48'hFFFF_FFFF_FFFF, '0, 1'b0, 1'b0, 32'hFFFF_FFF0);
      send_item(OP_ISSUE, 48'h0, '0, 1'b0, 1'b0, 32'd100);
      send_item(OP_ONESHOT, '0, '0, 1'b0, 1'b0, 32'd0);
      // bad id, unknown id, spoofed endpoint
      send_item(OP_RESPONSE, '0, 16'hFFFF, 1'b0, 1'b1, 32'd200);
      send_item(OP_RESPONSE, '0, 16'h0, 1'b1, 1'b0, 32'd200);
      t = tbl_txn[0];
      send_item(OP_RESPONSE, 48'h1, t, 1'b1, 1'b0, 32'd200);
      // wrapped send time -> age crosses zero; sent before now
      send_item(OP_RESPONSE, 48'hFFFF_FFFF_FFFF, t, 1'b1, 1'b1, 32'd5);
      t = tbl_txn[1];
      send_item(OP_RESPONSE, 48'h0, t, 1'b1, 1'b0, 32'd50);               // negative age
      // saturated round trip
      send_item(OP_ISSUE, 48'h1234, '0, 1'b0, 1'b0, 32'd0);
      send_item(OP_RESPONSE, 48'h1234, tbl_txn[0], 1'b1, 1'b0, 32'h7FFF_FFFF);
      send_item(OP_CANCEL, '0, 16'hBEEF, 1'b0, 1'b0, '0);                  // cancel miss
      send_item(OP_ISSUE, 48'h55, '0, 1'b1, 1'b1, 32'd0);
      send_item(OP_CANCEL, '0, tbl_txn[0], 1'b0, 1'b0, '0);
      send_item(3'd7, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send_item(3'd5, '0, '0, 1'b0, 1'b0, '0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < NSLOT + 2; i++)                 // fills, then overflows
         send_item(OP_ISSUE, rand_ep(), '0, 1'b0, 1'b0, 32'(i * 100));
      send_item(OP_ONESHOT, '0, '0, 1'b0, 1'b0, '0);      // redraw past all held ids
      send_item(OP_TICK, '0, '0, 1'b0, 1'b0, 32'd2000);   // shorts
      send_item(OP_TICK, '0, '0, 1'b0, 1'b0, 32'd2100);   // shorts fire once
      send_item(OP_TICK, '0, '0, 1'b0, 1'b0, 32'd15800);  // mix of fulls
      send_item(OP_TICK, '0, '0, 1'b0, 1'b0, 32'd40000);
   endtask

   task automatic test_random(int count, logic [TIME_W-1:0] step);
      int r;
      logic [TXN_W-1:0] t;
      for (int i = 0; i < count; i++) begin
         clk_ms = clk_ms + $urandom_range(step);
         r = $urandom_range(99);
         if (r < 30)
            send_item(OP_ISSUE, rand_ep(), 16'($urandom()), 1'($urandom()), 1'($urandom()),
                      clk_ms);
         else if (r < 55) begin
            t = some_pending_id();
            send_item(OP_RESPONSE, ($urandom_range(9) == 0) ? rand_ep() : ep_of(t), t,
                      $urandom_range(15) != 0, 1'($urandom()),
                      ($urandom_range(15) == 0) ? $urandom() : clk_ms);
         end else if (r < 72)
            send_item(OP_TICK, rand_ep(), 16'($urandom()), 1'($urandom()), 1'($urandom()),
                      clk_ms);
         else if (r < 82) begin
            t = ($urandom_range(3) == 0) ? 16'($urandom()) : some_pending_id();
            send_item(OP_CANCEL, rand_ep(), t, 1'($urandom()), 1'($urandom()), clk_ms);
         end else if (r < 94)
            send_item(OP_ONESHOT, rand_ep(), 16'($urandom()), 1'($urandom()), 1'($urandom()),
                      clk_ms);
         else
            send_item(3'($urandom_range(7, 5)), rand_ep(), 16'($urandom()), 1'($urandom()),
                      1'($urandom()), $urandom());
      end
   endtask

   task automatic test_settings();
      // zero timeouts: every tick frees everything
      write_reg(CSR_SHORT_TIMEOUT, 32'd0);
      write_reg(CSR_FULL_TIMEOUT, 32'd0);
      write_reg(CSR_ID_SEED, 32'd0);                      // loads as one
      test_random(60, 200);
      // huge timeouts: nothing times out
      write_reg(CSR_SHORT_TIMEOUT, 32'hFFFF_FFFF);
      write_reg(CSR_FULL_TIMEOUT, 32'hFFFF_FFFF);
      write_reg(CSR_ID_SEED, 32'hFFFF_FFFF);
      test_random(60, 30000);
      // short beyond full: only fulls
      write_reg(CSR_SHORT_TIMEOUT, 32'd900);
      write_reg(CSR_FULL_TIMEOUT, 32'd300);
      write_reg(CSR_ID_SEED, 32'd1);
      test_random(80, 120);
      write_reg(CSR_SHORT_TIMEOUT, 32'd150);
      write_reg(CSR_FULL_TIMEOUT, 32'd700);
      write_reg(CSR_ID_SEED, $urandom_range(16'hFFFF, 1));
      test_random(180, 90);
   endtask

   initial begin
      short_to = SHORT_RESET;
      full_to = FULL_RESET;
      lfsr = SEED_RESET;
      for (int i = 0; i < NSLOT; i++) begin
         pend[i] = 1'b0; fired[i] = 1'b0;
         tbl_txn[i] = '0; tbl_ep[i] = '0; tbl_sent[i] = '0;
      end
      foreach (kind_seen[i]) kind_seen[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_settings();
      drain();
      $display("%0d items sent, %0d results checked, kinds seen:", n_items, n_results);
      $display("  %p", kind_seen);
      if (errors == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
